// ===== rtl/waypoint_turn_and_move_planner_defines.svh =====
// assertion macros for the waypoint planner checker
`ifndef WAYPOINT_TURN_AND_MOVE_PLANNER_DEFINES_SVH
`define WAYPOINT_TURN_AND_MOVE_PLANNER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define WTMP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wtmp check failed");

// next-cycle implication, sampled on clk, off during reset
`define WTMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wtmp check failed");

`endif

// ===== rtl/wtmp_pkg.sv =====
// types, constants and the arctangent table of the waypoint planner
package wtmp_pkg;

    localparam int ITERS = 16;
    localparam int SQRT_STEPS = 13;
    localparam logic signed [15:0] DEG90 = 16'sd11520;
    localparam logic signed [15:0] DEG180 = 16'sd23040;
    localparam logic signed [16:0] DEG360 = 17'sd46080;
    localparam logic signed [27:0] ACC180 = 28'sd11796480;
    localparam logic [15:0] RECIP100 = 16'd41943;

    typedef enum logic [1:0] {
        CFG_TURN_RATE = 2'd0,
        CFG_MOVE_RATE = 2'd1,
        CFG_START_X   = 2'd2,
        CFG_START_Y   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [11:0] waypoint_x;
        logic [11:0] waypoint_y;
        logic        path_start;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] rotate_angle;
        logic [15:0]        turn_duration_ms;
        logic [12:0]        distance;
        logic [13:0]        move_duration_ms;
        logic signed [15:0] new_heading;
    } out_item_t;

    typedef struct packed {
        logic       accept;
        logic       load;
        logic       iter;
        logic [3:0] step;
        logic       fin1;
        logic       fin2;
        logic       fin3;
        logic       fin4;
    } cmd_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic [21:0] atan_entry(input logic [3:0] i);
        logic [21:0] a;
        unique case (i)
            4'd0:  a = 22'd2949120;
            4'd1:  a = 22'd1740967;
            4'd2:  a = 22'd919879;
            4'd3:  a = 22'd466945;
            4'd4:  a = 22'd234379;
            4'd5:  a = 22'd117304;
            4'd6:  a = 22'd58666;
            4'd7:  a = 22'd29335;
            4'd8:  a = 22'd14668;
            4'd9:  a = 22'd7334;
            4'd10: a = 22'd3667;
            4'd11: a = 22'd1833;
            4'd12: a = 22'd917;
            4'd13: a = 22'd458;
            4'd14: a = 22'd229;
            4'd15: a = 22'd115;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/wtmp_ctrl.sv =====
// sequencer: accept, load, cordic/sqrt iterations, finish steps, output slot
module wtmp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output wtmp_pkg::cmd_t cmd
);
    import wtmp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_ITER, S_F1, S_F2, S_F3, S_F4
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.accept = (state_reg == S_IDLE) && in_valid;
        cmd.load   = (state_reg == S_LOAD);
        cmd.iter   = (state_reg == S_ITER);
        cmd.step   = step_reg;
        cmd.fin1   = (state_reg == S_F1);
        cmd.fin2   = (state_reg == S_F2);
        cmd.fin3   = (state_reg == S_F3);
        cmd.fin4   = (state_reg == S_F4) && slot_free;
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                step_next  = '0;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(ITERS - 1))
                    state_next = S_F1;
            end
            S_F1: state_next = S_F2;
            S_F2: state_next = S_F3;
            S_F3: state_next = S_F4;
            S_F4:
            begin
                // hold the finished request until the output slot empties
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/wtmp_dpath.sv =====
// datapath: position and heading state, cordic vectoring, integer sqrt, timing
module wtmp_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wtmp_pkg::cmd_t       cmd,
    input  wtmp_pkg::in_item_t   in_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [11:0]          cfg_data,
    output wtmp_pkg::out_item_t  out_data
);
    import wtmp_pkg::*;

    // configuration and position state
    logic [7:0]         trate_reg, mrate_reg;
    logic [11:0]        sx_reg, sy_reg;
    logic [11:0]        last_x_reg, last_y_reg;
    logic signed [15:0] heading_reg;

    // working registers
    in_item_t           req_reg;
    logic signed [12:0] dx_reg, dy_reg;
    logic signed [31:0] cx_reg, cy_reg;
    logic signed [27:0] cz_reg;
    logic [25:0]        sqv_reg, sqr_reg;
    logic signed [15:0] ang_reg, rot_reg;
    logic [14:0]        mag_reg;
    logic [12:0]        dist_reg;
    logic [15:0]        turn_reg;
    logic [20:0]        mp_reg;
    logic [36:0]        qp_reg;
    out_item_t          out_reg;

    // load
    logic [11:0]        bx, by;
    logic signed [12:0] dx, dy;
    logic [11:0]        adx, ady;
    logic signed [31:0] x0, y0;
    logic signed [27:0] z0;

    always_comb
    begin
        bx  = req_reg.path_start ? sx_reg : last_x_reg;
        by  = req_reg.path_start ? sy_reg : last_y_reg;
        dx  = $signed({1'b0, req_reg.waypoint_x}) - $signed({1'b0, bx});
        dy  = $signed({1'b0, by}) - $signed({1'b0, req_reg.waypoint_y});
        adx = dx[12] ? 12'(-dx) : dx[11:0];
        ady = dy[12] ? 12'(-dy) : dy[11:0];
        // left half plane: rotate by 180 first
        if (dx[12])
        begin
            x0 = 32'(-dx) <<< 16;
            y0 = 32'(-dy) <<< 16;
            z0 = dy[12] ? -ACC180 : ACC180;
        end
        else
        begin
            x0 = 32'(dx) <<< 16;
            y0 = 32'(dy) <<< 16;
            z0 = '0;
        end
    end

    // one cordic micro-rotation per step, and one sqrt digit in each of the first SQRT_STEPS steps
    logic signed [31:0] xs, ys;
    logic signed [27:0] at;
    logic [25:0]        bitv, trial;

    always_comb
    begin
        xs    = cx_reg >>> cmd.step;
        ys    = cy_reg >>> cmd.step;
        at    = $signed({6'b0, atan_entry(cmd.step)});
        bitv  = 26'd1 << (5'd24 - {cmd.step, 1'b0});
        trial = sqr_reg + bitv;
    end

    // angle, rotation and magnitude
    logic signed [27:0] zr;
    logic signed [15:0] ang;
    logic signed [16:0] rot;

    always_comb
    begin
        zr = (cz_reg + 28'sd256) >>> 9;
        if (dx_reg == '0 && dy_reg == '0)
            ang = heading_reg;
        else if (dy_reg == '0)
            ang = dx_reg[12] ? DEG180 : 16'sd0;
        else if (dx_reg == '0)
            ang = dy_reg[12] ? -DEG90 : DEG90;
        else if (zr > 28'(DEG180))
            ang = DEG180;
        else if (zr < -28'(DEG180))
            ang = -DEG180;
        else
            ang = zr[15:0];
        rot = 17'(heading_reg) - 17'(ang);
        if (rot > 17'(DEG180))
            rot = rot - DEG360;
        else if (rot < -17'(DEG180))
            rot = rot + DEG360;
    end

    // divide by 100 with one correction step
    logic [14:0] q0;
    logic [20:0] rem;
    logic [14:0] q;

    always_comb
    begin
        q0  = qp_reg[36:22];
        rem = mp_reg - 21'(q0) * 21'd100;
        q   = (rem >= 21'd100) ? q0 + 15'd1 : q0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trate_reg   <= 8'd70;
            mrate_reg   <= 8'd25;
            sx_reg      <= 12'd0;
            sy_reg      <= 12'd320;
            last_x_reg  <= 12'd0;
            last_y_reg  <= 12'd320;
            heading_reg <= DEG90;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_TURN_RATE: trate_reg <= cfg_data[7:0];
                    CFG_MOVE_RATE: mrate_reg <= cfg_data[7:0];
                    CFG_START_X:   sx_reg    <= cfg_data;
                    CFG_START_Y:   sy_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                last_x_reg <= req_reg.waypoint_x;
                last_y_reg <= req_reg.waypoint_y;
                if (req_reg.path_start)
                    heading_reg <= DEG90;
            end
            if (cmd.fin1)
                heading_reg <= ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            req_reg <= in_data;
        if (cmd.load)
        begin
            dx_reg  <= dx;
            dy_reg  <= dy;
            cx_reg  <= x0;
            cy_reg  <= y0;
            cz_reg  <= z0;
            sqv_reg <= 26'(adx) * 26'(adx) + 26'(ady) * 26'(ady);
            sqr_reg <= '0;
        end
        if (cmd.iter)
        begin
            if (!cy_reg[31])
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + at;
            end
            else
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - at;
            end
            if (cmd.step < 4'(SQRT_STEPS))
            begin
                if (sqv_reg >= trial)
                begin
                    sqv_reg <= sqv_reg - trial;
                    sqr_reg <= (sqr_reg >> 1) + bitv;
                end
                else
                    sqr_reg <= sqr_reg >> 1;
            end
        end
        if (cmd.fin1)
        begin
            ang_reg  <= ang;
            rot_reg  <= rot[15:0];
            mag_reg  <= rot[16] ? 15'(-rot) : rot[14:0];
            dist_reg <= sqr_reg[12:0];
        end
        if (cmd.fin2)
        begin
            turn_reg <= 16'((23'(trate_reg) * 23'(mag_reg)) >> 7);
            mp_reg   <= 21'(mrate_reg) * 21'(dist_reg);
        end
        if (cmd.fin3)
            qp_reg <= 37'(mp_reg) * 37'(RECIP100);
        if (cmd.fin4)
        begin
            out_reg.rotate_angle     <= rot_reg;
            out_reg.turn_duration_ms <= turn_reg;
            out_reg.distance         <= dist_reg;
            out_reg.move_duration_ms <= q[13:0];
            out_reg.new_heading      <= ang_reg;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/waypoint_turn_and_move_planner.sv =====
// waypoint planner: heading, rotation, distance and timing per waypoint
// sequence from the accepted request to out_valid: load, 16 cordic
// steps that also carry the 13 sqrt digits, 4 finish steps; the last one fills the output register
// occupancy: one waypoint in flight at a time, a new request is accepted only when idle; a held result
// stalls the last finish step until the output slot empties
// reset: heading 90 degrees, position (0, 320), rates 70 and 25, start (0, 320)
module waypoint_turn_and_move_planner (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wtmp_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wtmp_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [11:0]          cfg_data
);
    import wtmp_pkg::*;

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    wtmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    wtmp_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/wtmp_checker.sv =====
// port checker for the waypoint planner and its bind
`include "waypoint_turn_and_move_planner_defines.svh"

module wtmp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input wtmp_pkg::out_item_t out_data
);
    import wtmp_pkg::*;

    // stalled result stays put
    `WTMP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    // one waypoint in flight at a time
    `WTMP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `WTMP_ASSERT_SAME(a_rot_range, out_valid,
        out_data.rotate_angle <= DEG180 && out_data.rotate_angle >= -DEG180)
    `WTMP_ASSERT_SAME(a_head_range, out_valid,
        out_data.new_heading <= DEG180 && out_data.new_heading >= -DEG180)

endmodule

bind waypoint_turn_and_move_planner wtmp_checker u_wtmp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
